// ----- src/vtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtf_pkg
// Shared constants, types and fixed-point helpers for the vertex transform.
// ----------------------------------------------------------------------------
package vtf_pkg;
  localparam int FRACTION_BITS = 16;
  localparam int ROWS = 10;
  localparam int LANES = 8;

  // 2^FRACTION_BITS = 255 * CH_K + CH_R
  localparam int CH_R = 1 << (FRACTION_BITS % 8);
  localparam int CH_K = ((1 << FRACTION_BITS) - CH_R) / 255;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_POS  = 2'd1,
    FUNC_MAT  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNLD  = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef logic signed [31:0] word_t;
  typedef word_t row_t [4];

  typedef struct packed {
    logic   vld;
    func_t  func;
    logic   unld;
  } ctl_t;

  localparam logic signed [65:0] SMAX = 66'sd2147483647;
  localparam logic signed [65:0] SMIN = -66'sd2147483648;

  function automatic logic signed [65:0] fx_mul(input word_t a, input word_t b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    p = p + (66'sd1 <<< (FRACTION_BITS - 1));
    return p >>> FRACTION_BITS;
  endfunction

  function automatic logic is_sat(input logic signed [65:0] v);
    return (v > SMAX) || (v < SMIN);
  endfunction

  function automatic word_t sat32(input logic signed [65:0] v);
    if (v > SMAX) return 32'sh7fffffff;
    if (v < SMIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  // (c * 2^F + 127) / 255 = c * CH_K + (c * CH_R + 127) / 255;
  // the small quotient uses the exact 16-bit reciprocal 0x8081 >> 23
  function automatic word_t chan(input logic [7:0] c);
    logic [15:0] t;
    logic [31:0] m;
    t = 16'(c) * 16'(CH_R) + 16'd127;
    m = 32'(t) * 32'h8081;
    return word_t'(32'(CH_K) * 32'(c) + (m >> 23));
  endfunction
endpackage
`default_nettype wire

// ----- src/vtf_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtf_lane
// One dot-product lane: four products registered, then summed and saturated.
// ----------------------------------------------------------------------------
module vtf_lane
  import vtf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  en,
  input  word_t      q [4],
  input  word_t      r [4],
  output word_t      dot,
  output logic       sat
);
  logic signed [65:0] p_r [4];
  logic signed [67:0] sum;

  always_comb begin
    sum = 68'(p_r[0]) + 68'(p_r[1]) + 68'(p_r[2]) + 68'(p_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) p_r[j] <= fx_mul(q[j], r[j]);
    end
  end

  assign dot = (sum > 68'(SMAX)) ? 32'sh7fffffff :
               (sum < 68'(SMIN)) ? 32'sh80000000 : sum[31:0];
  assign sat = (sum > 68'(SMAX)) || (sum < 68'(SMIN));
endmodule
`default_nettype wire

// ----- src/vertex_transform_fog.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_transform_fog
// Fixed-point vertex transform with linear fog, eight dot-product lanes.
// ----------------------------------------------------------------------------
// Input transactions (valid/stall) carry a func code: load a constant row,
// transform a position, evaluate a material, or do nothing. Each yields one result
// transaction on the out_ channel.
// Pipeline: S1 forms q, S2 registers lane products, S3 sums the lanes and
// forms fog distance product, S4 forms fog and registers the result.
// Throughput is one transaction per cycle, set by the fully pipelined lanes,
// while the output is not stalled. The pipe advances only while the output
// register is free or being taken; out_stall holds the whole pipe.
// A load writes the row table at acceptance, so following items see it;
// each item captures the rows it uses when it enters S1.
// Reset clears valid bits and the row-loaded mask; table contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module vertex_transform_fog
  import vtf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [3:0]  in_row_index,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  input  wire logic signed [31:0] in_w,
  input  wire logic signed [31:0] in_u0,
  input  wire logic signed [31:0] in_u1,
  input  wire logic signed [31:0] in_u2,
  input  wire logic signed [31:0] in_u3,
  input  wire logic [31:0] in_color,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic signed [31:0] out_slot0,
  output logic signed [31:0] out_slot1,
  output logic signed [31:0] out_slot2,
  output logic signed [31:0] out_slot3,
  output logic signed [31:0] out_slot4,
  output logic signed [31:0] out_slot5,
  output logic signed [31:0] out_slot6,
  output logic signed [31:0] out_slot7,
  output logic signed [31:0] out_slot8,
  output logic signed [31:0] out_slot9
);
  word_t tbl_r [ROWS][4];
  logic [ROWS-1:0] loaded_r;
  logic adv, acc;

  ctl_t c1_r, c2_r, c3_r;
  word_t q1_r [4];
  logic  s1_r, s2_r;
  word_t u_r [2][4];
  word_t uu_r [2][4];
  word_t col_r [4], col2_r [4], col3_r [4];
  word_t dot [LANES];
  logic  lsat [LANES];
  word_t d3_r [LANES];
  logic  s3_r;
  logic signed [65:0] fp_r;
  word_t row1_r [LANES][4];
  // row 9 elements 0, 2, 3 per stage
  word_t f1_r [3], f2_r [3], f3_r [3];

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign acc = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
    end else if (acc && in_func == FUNC_LOAD && in_row_index < 4'(ROWS)) begin
      loaded_r[in_row_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_func == FUNC_LOAD && in_row_index < 4'(ROWS)) begin
      tbl_r[in_row_index][0] <= in_x;
      tbl_r[in_row_index][1] <= in_y;
      tbl_r[in_row_index][2] <= in_z;
      tbl_r[in_row_index][3] <= in_w;
    end
  end

  // stage 1: q vector
  logic signed [65:0] qm [4];
  logic [9:0] need;
  always_comb begin
    qm[0] = fx_mul(in_x, tbl_r[0][1]) + 66'(tbl_r[0][0]);
    qm[1] = fx_mul(in_y, tbl_r[0][1]) + 66'(tbl_r[0][0]);
    qm[2] = fx_mul(in_z, tbl_r[0][1]) + 66'(tbl_r[0][0]);
    qm[3] = fx_mul(in_x, tbl_r[0][0]) + 66'(tbl_r[0][1]);
    need = (in_func == FUNC_POS) ? 10'h0ff : 10'h3ff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0; c2_r <= '0; c3_r <= '0;
    end else if (adv) begin
      c1_r <= '{vld: in_valid, func: func_t'(in_func),
                unld: (loaded_r & need) != need};
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) q1_r[j] <= sat32(qm[j]);
      s1_r <= is_sat(qm[0]) || is_sat(qm[1]) || is_sat(qm[2]) || is_sat(qm[3]);
      for (int l = 0; l < LANES; l++) row1_r[l] <= tbl_r[l+1];
      f1_r <= '{tbl_r[9][0], tbl_r[9][2], tbl_r[9][3]};
      f2_r <= f1_r;
      u_r[0][0] <= in_u0;
      u_r[0][1] <= in_u1;
      u_r[0][2] <= sat32(fx_mul(in_u2, tbl_r[0][1]));
      u_r[0][3] <= sat32(fx_mul(in_u3, tbl_r[0][1]));
      u_r[1][0] <= {31'd0, is_sat(fx_mul(in_u2, tbl_r[0][1])) ||
                           is_sat(fx_mul(in_u3, tbl_r[0][1]))};
      u_r[1][1] <= '0; u_r[1][2] <= '0; u_r[1][3] <= '0;
      col_r[0] <= chan(in_color[23:16]);
      col_r[1] <= chan(in_color[15:8]);
      col_r[2] <= chan(in_color[7:0]);
      col_r[3] <= chan(in_color[31:24]);
      s2_r <= s1_r;
      uu_r <= u_r;
      col2_r <= col_r;
      col3_r <= col2_r;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    vtf_lane u_lane (
      .clk (clk),
      .en  (adv),
      .q   (q1_r),
      .r   (row1_r[l]),
      .dot (dot[l]),
      .sat (lsat[l])
    );
  end

  // stage 3: merge lanes, start fog product
  logic s3_nxt;
  logic s3u_r;
  word_t u3_r [4];
  always_comb begin
    s3_nxt = s2_r;
    for (int l = 0; l < LANES - 1; l++) s3_nxt = s3_nxt || lsat[l];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) d3_r[l] <= dot[l];
      s3_r <= s3_nxt;
      s3u_r <= lsat[LANES-1] || uu_r[1][0][0];
      fp_r <= fx_mul(dot[LANES-1], f2_r[2]);
      f3_r <= f2_r;
      u3_r <= uu_r[0];
    end
  end

  // stage 4: fog and result
  logic signed [65:0] fd;
  word_t fog;
  logic fsat;
  always_comb begin
    fd = 66'(f3_r[0]) - 66'(sat32(fp_r));
    fog = sat32(fd);
    fsat = is_sat(fp_r) || is_sat(fd);
    if (fog < f3_r[1]) fog = f3_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c3_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status <= ST_OK;
      {out_slot0, out_slot1, out_slot2, out_slot3, out_slot4,
       out_slot5, out_slot6, out_slot7, out_slot8, out_slot9} <= '0;
      if ((c3_r.func == FUNC_POS || c3_r.func == FUNC_MAT) && c3_r.unld) begin
        out_status <= ST_UNLD;
      end else if (c3_r.func == FUNC_POS) begin
        out_status <= s3_r ? ST_SAT : ST_OK;
        out_slot0 <= d3_r[0]; out_slot1 <= d3_r[1];
        out_slot2 <= d3_r[2]; out_slot3 <= d3_r[3];
        out_slot4 <= d3_r[4]; out_slot5 <= d3_r[5];
        out_slot6 <= d3_r[6];
        out_slot7 <= 32'sd1 <<< FRACTION_BITS;
      end else if (c3_r.func == FUNC_MAT) begin
        out_status <= (s3_r || s3u_r || fsat) ? ST_SAT : ST_OK;
        out_slot0 <= u3_r[0]; out_slot1 <= u3_r[1];
        out_slot2 <= u3_r[2]; out_slot3 <= u3_r[3];
        out_slot4 <= col3_r[0]; out_slot5 <= col3_r[1];
        out_slot6 <= col3_r[2]; out_slot7 <= col3_r[3];
        out_slot8 <= d3_r[7];
        out_slot9 <= fog;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot0) && $stable(out_status))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNLD |-> out_slot0 == 0 && out_slot9 == 0)
    else $error("unloaded result carries data");
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vertex_transform_fog: drives loads, position,
// material and no-op transactions with random idling and stalls, predicts each result
// from a private copy of the constant table and compares every field.
// ----------------------------------------------------------------------------
module tb_top;
  import vtf_pkg::*;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] slot [10];
  } vtx_result_t;

  class vtx_scoreboard;
    logic signed [31:0] table_q [40];
    bit [9:0]           loaded;
    vtx_result_t        pending [$];
    int                 errors;
    bit                 sat_flag;

    function logic signed [63:0] sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
        sat_flag = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat_flag = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function logic signed [63:0] mul(input logic signed [63:0] a, input logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b + 64'sd32768;
      return p >>> 16;
    endfunction

    function logic signed [63:0] dot(input logic signed [63:0] q [4], input int r);
      logic signed [63:0] s;
      s = 0;
      for (int j = 0; j < 4; j++) s += mul(q[j], 64'(table_q[r * 4 + j]));
      return sat(s);
    endfunction

    function logic signed [31:0] chan(input logic [7:0] c);
      logic [31:0] n;
      n = ((32'(c) << 16) + 127) / 255;
      return n;
    endfunction

    function void note_input(input logic [1:0] f, input logic [3:0] r,
                             input logic signed [31:0] v [10], input logic [31:0] col);
      vtx_result_t e;
      logic signed [63:0] a, b, q [4], d, fog;
      logic [9:0] need;
      e.status = ST_OK;
      for (int i = 0; i < 10; i++) e.slot[i] = 0;
      sat_flag = 0;
      if (f == FUNC_LOAD) begin
        if (r < 10) begin
          for (int j = 0; j < 4; j++) table_q[r * 4 + j] = v[j];
          loaded[r] = 1;
        end
      end else if (f == FUNC_POS || f == FUNC_MAT) begin
        need = (f == FUNC_POS) ? 10'h0ff : 10'h3ff;
        if ((loaded & need) != need) e.status = ST_UNLD;
        else begin
          a = 64'(table_q[0]);
          b = 64'(table_q[1]);
          q[0] = sat(mul(64'(v[0]), b) + a);
          q[1] = sat(mul(64'(v[1]), b) + a);
          q[2] = sat(mul(64'(v[2]), b) + a);
          q[3] = sat(mul(64'(v[0]), a) + b);
          for (int i = 0; i < 7; i++) e.slot[i] = 32'(dot(q, i + 1));
          e.slot[7] = 32'sd65536;
          if (f == FUNC_MAT) begin
            e.slot[0] = v[4];
            e.slot[1] = v[5];
            e.slot[2] = 32'(sat(mul(64'(v[6]), b)));
            e.slot[3] = 32'(sat(mul(64'(v[7]), b)));
            e.slot[4] = chan(col[23:16]);
            e.slot[5] = chan(col[15:8]);
            e.slot[6] = chan(col[7:0]);
            e.slot[7] = chan(col[31:24]);
            d = dot(q, 8);
            fog = sat(64'(table_q[36]) - sat(mul(d, 64'(table_q[39]))));
            if (fog < 64'(table_q[38])) fog = 64'(table_q[38]);
            e.slot[8] = 32'(d);
            e.slot[9] = 32'(fog);
          end
          if (sat_flag) e.status = ST_SAT;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(input vtx_result_t got);
      vtx_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.status !== got.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      for (int i = 0; i < 10; i++)
        if (e.slot[i] !== got.slot[i]) begin
          $display("%0t: slot%0d expected %h actual %h", $time, i, e.slot[i], got.slot[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] in_func, out_status;
  logic [3:0] in_row_index;
  logic signed [31:0] in_x, in_y, in_z, in_w, in_u0, in_u1, in_u2, in_u3;
  logic [31:0] in_color;
  logic signed [31:0] out_slot0, out_slot1, out_slot2, out_slot3, out_slot4;
  logic signed [31:0] out_slot5, out_slot6, out_slot7, out_slot8, out_slot9;

  vertex_transform_fog uut (.*);

  vtx_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int hold_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_top failed");
    $finish;
  end

  // receiver
  always @(posedge clk) begin
    vtx_result_t g;
    if (rst_n && out_valid && !out_stall) begin
      g.status = out_status;
      g.slot = '{out_slot0, out_slot1, out_slot2, out_slot3, out_slot4,
                 out_slot5, out_slot6, out_slot7, out_slot8, out_slot9};
      sb.check_result(g);
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(131072)) - 32'sd65536;
      3: return $signed($urandom_range(2097152)) - 32'sd1048576;
      default: return $urandom;
    endcase
  endfunction

  function logic signed [31:0] rand_coef();
    if ($urandom_range(9) == 0) return rand_word();
    return $signed($urandom_range(196608)) - 32'sd98304;
  endfunction

  task automatic send(input logic [1:0] f, input logic [3:0] r,
                      input logic signed [31:0] v [8], input logic [31:0] col);
    logic signed [31:0] all [10];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_func <= f;
    in_row_index <= r;
    {in_x, in_y, in_z, in_w} <= {v[0], v[1], v[2], v[3]};
    {in_u0, in_u1, in_u2, in_u3} <= {v[4], v[5], v[6], v[7]};
    in_color <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    for (int i = 0; i < 8; i++) all[i] = v[i];
    sb.note_input(f, r, all, col);
  endtask

  task automatic send_load(input int r, input bit wide);
    logic signed [31:0] v [8];
    for (int i = 0; i < 8; i++) v[i] = wide ? rand_word() : rand_coef();
    send(FUNC_LOAD, r[3:0], v, $urandom);
  endtask

  task automatic send_vertex(input logic [1:0] f);
    logic signed [31:0] v [8];
    for (int i = 0; i < 8; i++) v[i] = rand_word();
    send(f, 4'($urandom_range(15)), v, $urandom);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] v [8];
    sb = new();
    sb.loaded = 0;
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    in_func = FUNC_LOAD;
    in_row_index = 0;
    {in_x, in_y, in_z, in_w, in_u0, in_u1, in_u2, in_u3, in_color} = '0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: unloaded rows, odd func, out-of-range load, extremes
    send_vertex(FUNC_POS);
    send_vertex(FUNC_MAT);
    send_vertex(FUNC_NONE);
    send_load(12, 0);
    send_load(15, 1);
    for (int r = 0; r < 8; r++) send_load(r, 0);
    send_vertex(FUNC_POS);
    send_vertex(FUNC_MAT);
    send_load(8, 0);
    send_load(9, 0);
    for (int i = 0; i < 8; i++) v[i] = 32'sh7fffffff;
    send(FUNC_MAT, 4'd0, v, 32'hffffffff);
    for (int i = 0; i < 8; i++) v[i] = 32'sh80000000;
    send(FUNC_MAT, 4'd15, v, 32'h0);
    for (int i = 0; i < 8; i++) v[i] = 0;
    send(FUNC_POS, 4'd3, v, 32'h80ff7f01);
    send_load(0, 1);
    send_vertex(FUNC_MAT);
    drain();

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 35 : 0;
      for (int n = 0; n < 400; n++) begin
        if (n == 100) hold_cycles = 60;
        if (n == 200) drain();
        case ($urandom_range(9))
          0: send_load($urandom_range(10), $urandom_range(3) == 0);
          1: send_vertex(FUNC_NONE);
          2, 3, 4: send_vertex(FUNC_POS);
          default: send_vertex(FUNC_MAT);
        endcase
      end
    end

    in_valid <= 0;
    fork
      while (sb.pending.size() != 0) @(posedge clk);
      begin
        repeat (200000) @(posedge clk);
        $display("tb_top failed");
        $finish;
      end
    join_any
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
